// ----- sv/mte_pkg.sv -----
// shared types and constants for the midi track note-on extractor
// no dependencies; used by mte_parse, mte_out and the top level
`default_nettype none

package mte_pkg;

  // parse position inside the track event stream
  typedef enum logic [2:0] {
    PH_HALTED    = 3'd0,
    PH_DELTA     = 3'd1,
    PH_STATUS    = 3'd2,
    PH_META_TYPE = 3'd3,
    PH_LENGTH    = 3'd4,
    PH_SKIP      = 3'd5,
    PH_DATA1     = 3'd6,
    PH_DATA2     = 3'd7
  } phase_t;

  // start marker codes carried with each byte
  localparam logic [1:0] KIND_CONT  = 2'd0;
  localparam logic [1:0] KIND_TRACK = 2'd1;
  localparam logic [1:0] KIND_FILE  = 2'd2;

  // status bytes and masks
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_MTC_QF    = 8'hF1;
  localparam logic [7:0] ST_SONG_POS  = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
  localparam logic [7:0] ST_TUNE_REQ  = 8'hF6;
  localparam logic [7:0] ST_CLOCK     = 8'hF8;
  localparam logic [7:0] ST_START     = 8'hFA;
  localparam logic [7:0] ST_CONTINUE  = 8'hFB;
  localparam logic [7:0] ST_STOP      = 8'hFC;
  localparam logic [7:0] ST_SENSE     = 8'hFE;
  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
  localparam logic [3:0] CMD_PROGRAM  = 4'hC;
  localparam logic [3:0] CMD_PRESSURE = 4'hD;
  localparam logic [3:0] CMD_SYSTEM   = 4'hF;

  localparam int unsigned TICK_W  = 32;
  localparam int unsigned QTY_W   = 28;
  localparam int unsigned BYTE_W  = 8;
  localparam logic [1:0]  QTY_MAX_BYTES = 2'd3;

  // one result beat
  typedef struct packed {
    logic              event_valid;
    logic [TICK_W-1:0] event_tick;
    logic [3:0]        channel;
    logic [BYTE_W-1:0] note;
    logic [BYTE_W-1:0] velocity;
    logic [TICK_W-1:0] max_tick;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/mte_parse.sv -----
// parse state registers and per-byte next-state logic of the note-on extractor
// depends on mte_pkg
`default_nettype none

module mte_parse (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      byte_en,
  input  wire logic [7:0]                data_byte,
  input  wire logic [1:0]                start_kind,
  output mte_pkg::result_t               result
);

  mte_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [31:0] largest_r, largest_nxt;
  logic [7:0]  running_r, running_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [27:0] accum_r, accum_nxt;
  logic [1:0]  qbytes_r, qbytes_nxt;
  logic [27:0] skip_r, skip_nxt;
  logic [7:0]  first_r, first_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= mte_pkg::PH_HALTED;
      tick_r    <= '0;
      largest_r <= '0;
      running_r <= '0;
      held_r    <= '0;
      accum_r   <= '0;
      qbytes_r  <= '0;
      skip_r    <= '0;
      first_r   <= '0;
    end else if (byte_en) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      largest_r <= largest_nxt;
      running_r <= running_nxt;
      held_r    <= held_nxt;
      accum_r   <= accum_nxt;
      qbytes_r  <= qbytes_nxt;
      skip_r    <= skip_nxt;
      first_r   <= first_nxt;
    end
  end

  always_comb begin
    logic        restart;
    logic [27:0] acc_shift;
    logic [27:0] skip_dec;
    logic [31:0] tick_sum;
    logic [3:0]  cmd;
    logic [3:0]  run_cmd;

    restart = (start_kind == mte_pkg::KIND_TRACK) || (start_kind == mte_pkg::KIND_FILE);

    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    largest_nxt = largest_r;
    running_nxt = running_r;
    held_nxt    = held_r;
    accum_nxt   = accum_r;
    qbytes_nxt  = qbytes_r;
    skip_nxt    = skip_r;
    first_nxt   = first_r;
    result      = '0;

    // track start clears the position; file start also the maximum
    if (restart) begin
      if (start_kind == mte_pkg::KIND_FILE) begin
        largest_nxt = '0;
      end
      tick_nxt    = '0;
      running_nxt = '0;
      held_nxt    = '0;
      skip_nxt    = '0;
      first_nxt   = '0;
      accum_nxt   = '0;
      qbytes_nxt  = '0;
      phase_nxt   = mte_pkg::PH_DELTA;
    end

    acc_shift = {accum_nxt[20:0], data_byte[6:0]};
    skip_dec  = (skip_nxt != '0) ? skip_nxt - 28'd1 : skip_nxt;
    tick_sum  = tick_nxt + {4'b0, acc_shift};
    cmd       = held_nxt[7:4];
    run_cmd   = running_nxt[7:4];

    case (phase_nxt)
      mte_pkg::PH_DELTA: begin
        accum_nxt = acc_shift;
        if (!data_byte[7]) begin
          tick_nxt = tick_sum;
          if (tick_sum > largest_nxt) begin
            largest_nxt = tick_sum;
          end
          accum_nxt  = '0;
          qbytes_nxt = '0;
          phase_nxt  = mte_pkg::PH_STATUS;
        end else if (qbytes_nxt >= mte_pkg::QTY_MAX_BYTES) begin
          phase_nxt = mte_pkg::PH_HALTED;
        end else begin
          qbytes_nxt = qbytes_nxt + 2'd1;
        end
      end
      mte_pkg::PH_STATUS: begin
        if (!data_byte[7]) begin
          // running status: this byte is the first data byte
          if (running_nxt == '0) begin
            phase_nxt = mte_pkg::PH_HALTED;
          end else begin
            held_nxt  = running_nxt;
            first_nxt = data_byte;
            if (run_cmd == mte_pkg::CMD_PROGRAM || run_cmd == mte_pkg::CMD_PRESSURE) begin
              phase_nxt = mte_pkg::PH_DELTA;
            end else begin
              phase_nxt = mte_pkg::PH_DATA2;
            end
          end
        end else if (data_byte[7:4] != mte_pkg::CMD_SYSTEM) begin
          running_nxt = data_byte;
          held_nxt    = data_byte;
          phase_nxt   = mte_pkg::PH_DATA1;
        end else begin
          case (data_byte)
            mte_pkg::ST_META: phase_nxt = mte_pkg::PH_META_TYPE;
            mte_pkg::ST_SYSEX, mte_pkg::ST_SYSEX_ESC: begin
              running_nxt = '0;
              accum_nxt   = '0;
              qbytes_nxt  = '0;
              phase_nxt   = mte_pkg::PH_LENGTH;
            end
            mte_pkg::ST_MTC_QF, mte_pkg::ST_SONG_SEL: begin
              skip_nxt  = 28'd1;
              phase_nxt = mte_pkg::PH_SKIP;
            end
            mte_pkg::ST_SONG_POS: begin
              skip_nxt  = 28'd2;
              phase_nxt = mte_pkg::PH_SKIP;
            end
            mte_pkg::ST_TUNE_REQ, mte_pkg::ST_CLOCK, mte_pkg::ST_START,
            mte_pkg::ST_CONTINUE, mte_pkg::ST_STOP, mte_pkg::ST_SENSE: begin
              phase_nxt = mte_pkg::PH_DELTA;
            end
            default: phase_nxt = mte_pkg::PH_HALTED;
          endcase
        end
      end
      mte_pkg::PH_META_TYPE: begin
        accum_nxt  = '0;
        qbytes_nxt = '0;
        phase_nxt  = mte_pkg::PH_LENGTH;
      end
      mte_pkg::PH_LENGTH: begin
        accum_nxt = acc_shift;
        if (!data_byte[7]) begin
          skip_nxt   = acc_shift;
          accum_nxt  = '0;
          qbytes_nxt = '0;
          phase_nxt  = (acc_shift == '0) ? mte_pkg::PH_DELTA : mte_pkg::PH_SKIP;
        end else if (qbytes_nxt >= mte_pkg::QTY_MAX_BYTES) begin
          phase_nxt = mte_pkg::PH_HALTED;
        end else begin
          qbytes_nxt = qbytes_nxt + 2'd1;
        end
      end
      mte_pkg::PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt = mte_pkg::PH_DELTA;
        end
      end
      mte_pkg::PH_DATA1: begin
        first_nxt = data_byte;
        if (cmd == mte_pkg::CMD_PROGRAM || cmd == mte_pkg::CMD_PRESSURE) begin
          phase_nxt = mte_pkg::PH_DELTA;
        end else begin
          phase_nxt = mte_pkg::PH_DATA2;
        end
      end
      mte_pkg::PH_DATA2: begin
        if (cmd == mte_pkg::CMD_NOTE_ON && data_byte != '0) begin
          result.event_valid = 1'b1;
          result.event_tick  = tick_nxt;
          result.channel     = held_nxt[3:0];
          result.note        = first_nxt;
          result.velocity    = data_byte;
        end
        phase_nxt = mte_pkg::PH_DELTA;
      end
      default: begin
        // halted: byte ignored
      end
    endcase

    result.max_tick = largest_nxt;
  end

endmodule

`default_nettype wire

// ----- sv/mte_out.sv -----
// result register of the note-on extractor, one beat deep, with ready back-pressure
// depends on mte_pkg
`default_nettype none

module mte_out (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      load,
  input  wire mte_pkg::result_t          result_in,
  input  wire logic                      take,
  output logic                           space,
  output logic                           valid,
  output mte_pkg::result_t               result_out
);

  logic             valid_r;
  mte_pkg::result_t data_r;

  // free when empty or when the held beat leaves this cycle
  assign space = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result_in;
    end
  end

  assign valid      = valid_r;
  assign result_out = data_r;

endmodule

`default_nettype wire

// ----- sv/midi_track_note_on_extractor_top.sv -----
// top level of the midi track note-on extractor
// instantiates mte_parse and mte_out; depends on mte_pkg
`default_nettype none

// usage
//   in channel: one track byte per beat in in_tdata, with in_tuser marking
//   continue (0), first byte of a new track (1) or of a new file (2); code 3
//   counts as continue
//   out channel: exactly one result beat per input beat, in order; out_tuser
//   flags a note-on with nonzero velocity, out_tdata carries tick, channel,
//   note, velocity (zero unless flagged) and the running file-wide max tick
//   a byte's result is registered and shown in the cycle after it is taken
//   throughput: one byte per cycle with out_tready high; the parse state
//   updates in one pass of logic; the result sits in one output register
//   stall: while the output register holds a beat that out_tready does not
//   take, in_tready is low; when out_tready is high a new byte enters in the
//   same cycle as the held beat leaves, so no bubble appears
//   reset: parsing is halted until the first track start, ticks and running
//   status are zero, the output register is empty
//   parse errors (overlong quantity, data with no running status, undefined
//   system status) halt until the next track start; results then carry only
//   the max tick

module midi_track_note_on_extractor_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [1:0]  in_tuser,   // [1:0] start_kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,  // [31:0] event_tick, [35:32] channel,
                                       // [43:36] note, [51:44] velocity,
                                       // [83:52] max_tick, [87:84] zero
  output logic [0:0]       out_tuser   // [0] event_valid
);

  logic             in_beat;
  logic             out_space;
  mte_pkg::result_t parse_result;
  mte_pkg::result_t held_result;

  // byte taken when the output register has room this cycle
  assign in_tready = out_space;
  assign in_beat   = in_tvalid && in_tready;

  mte_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_en    (in_beat),
    .data_byte  (in_tdata),
    .start_kind (in_tuser),
    .result     (parse_result)
  );

  mte_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_beat),
    .result_in  (parse_result),
    .take       (out_tready),
    .space      (out_space),
    .valid      (out_tvalid),
    .result_out (held_result)
  );

  // pack result fields, first field lowest
  assign out_tdata = {4'b0000, held_result.max_tick, held_result.velocity,
                      held_result.note, held_result.channel, held_result.event_tick};
  assign out_tuser = held_result.event_valid;

`ifndef SYNTHESIS
  // a flagged note-on never carries zero velocity
  a_vel_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[51:44] != 8'd0)
    else $error("note-on beat with zero velocity");

  // the first byte of a track can never complete a note-on
  a_no_event_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_tuser == mte_pkg::KIND_TRACK || in_tuser == mte_pkg::KIND_FILE)
    |=> out_tvalid && !out_tuser[0])
    else $error("note-on reported on a track start byte");

  // a file start with a continuing delta byte leaves the max tick cleared
  a_file_clears_max: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && in_tuser == mte_pkg::KIND_FILE && in_tdata[7]
    |=> out_tvalid && out_tdata[83:52] == 32'd0)
    else $error("max tick not cleared at file start");

  // each accepted byte leaves a result beat waiting
  a_beat_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> out_tvalid)
    else $error("accepted byte produced no result beat");
`endif

endmodule

`default_nettype wire
